// ----- sv/crpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package crpd_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_IDENT = 2'd0,
        CMD_LOAD_COUNT = 2'd1,
        CMD_LOAD_DESC  = 2'd2,
        CMD_FRAME      = 2'd3
    } t_cmd;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned MAX_BYTES = 8;
    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_DATA_W = 64;

    // one queued transaction, already classified
    typedef struct packed {
        t_cmd         cmd;
        logic [1:0]   slot;
        logic [2:0]   entry;
        logic [31:0]  word;
        logic [10:0]  fid;
        logic [3:0]   fsize;   // saturated to MAX_BYTES
        logic [63:0]  data;
        logic         ok;      // load target in range
    } t_item;

endpackage
`default_nettype wire

// ----- sv/crpd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crpd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/crpd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crpd_front #(
    parameter int unsigned SLOTS       = 4,
    parameter int unsigned MAX_ENTRIES = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic [crpd_pkg::IN_DATA_W-1:0]     i_data,
    output logic                                    o_avail,
    output crpd_pkg::t_item                         o_item,
    input  wire logic                               i_pop
);
    crpd_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    crpd_pkg::t_item w_item;
    logic            w_push;

    assign o_ready = (r_cnt != 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;

    always_comb begin
        w_item.cmd   = crpd_pkg::t_cmd'(i_cmd);
        w_item.slot  = i_data[1:0];
        w_item.entry = i_data[4:2];
        w_item.word  = i_data[36:5];
        w_item.fid   = i_data[47:37];
        w_item.fsize = (i_data[51:48] > 4'(crpd_pkg::MAX_BYTES))
                       ? 4'(crpd_pkg::MAX_BYTES) : i_data[51:48];
        w_item.data  = i_data[115:52];
        w_item.ok    = (32'(i_data[1:0]) < SLOTS) &&
                       ((w_item.cmd != crpd_pkg::CMD_LOAD_DESC) ||
                        (32'(i_data[4:2]) < MAX_ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ----- sv/crpd_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crpd_engine #(
    parameter int unsigned SLOTS       = 4,
    parameter int unsigned MAX_ENTRIES = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_avail,
    input  wire crpd_pkg::t_item                    i_item,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [crpd_pkg::OUT_DATA_W-1:0]         o_data,
    output logic                                    o_kind,
    output logic                                    o_last
);
    localparam int unsigned DEPTH = SLOTS * MAX_ENTRIES;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SLOT, ST_ENTRY, ST_EXEC, ST_END, ST_NEXT, ST_VERDICT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_idw [SLOTS];
    logic            r_idl [SLOTS];
    logic [7:0]      r_mcnt [SLOTS];
    logic            r_dld [DEPTH];
    logic [SW-1:0]   r_slot;
    logic [3:0]      r_entry;
    logic [3:0]      r_off;
    logic            r_acc;
    logic [10:0]     r_fid;
    logic [3:0]      r_fsize;
    logic [63:0]     r_fdata;

    logic [AW-1:0]   w_raddr, w_waddr;
    logic [31:0]     w_desc;
    logic            w_we;
    logic            w_free;
    logic            w_emit;
    logic [SW-1:0]   w_lslot;
    logic [2:0]      w_bytes;
    logic            w_wok;
    logic [31:0]     w_val;
    logic [4:0]      w_need;

    assign w_free  = !o_valid || i_ready;
    assign w_lslot = SW'(i_item.slot);
    assign w_raddr = AW'(32'(r_slot) * MAX_ENTRIES + 32'(r_entry));
    assign w_waddr = AW'(32'(w_lslot) * MAX_ENTRIES + 32'(i_item.entry));
    assign w_we    = (r_state == ST_IDLE) && i_avail && i_item.ok &&
                     (i_item.cmd == crpd_pkg::CMD_LOAD_DESC);
    assign o_pop   = (r_state == ST_IDLE) && i_avail;
    // a new transaction is loaded into the output register this cycle
    assign w_emit  = w_free &&
                     (((r_state == ST_EXEC) && w_wok && (w_need <= 5'(r_fsize))) ||
                      (r_state == ST_VERDICT));

    crpd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_desc (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_item.word),
        .i_raddr(w_raddr),
        .o_rdata(w_desc)
    );

    always_comb begin
        case (w_desc[7:0]) inside
            8'd8, 8'd16, 8'd24, 8'd32: w_wok = r_dld[w_raddr];
            default:                   w_wok = 1'b0;
        endcase
        w_bytes = w_desc[5:3];
        w_need  = 5'(r_off) + 5'(w_bytes);
        w_val   = 32'(r_fdata >> {r_off, 3'b000}) &
                  ~(32'hffff_ffff << {w_bytes, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_idl[i]  <= 1'b0;
                r_mcnt[i] <= 8'd0;
            end
            for (int i = 0; i < DEPTH; i++) begin
                r_dld[i] <= 1'b0;
            end
        end else begin
            if (o_valid && i_ready && !w_emit) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_avail) begin
                        case (i_item.cmd)
                            crpd_pkg::CMD_LOAD_IDENT: begin
                                if (i_item.ok) begin
                                    r_idw[w_lslot] <= i_item.word;
                                    r_idl[w_lslot] <= 1'b1;
                                end
                            end
                            crpd_pkg::CMD_LOAD_COUNT: begin
                                if (i_item.ok) r_mcnt[w_lslot] <= i_item.word[7:0];
                            end
                            crpd_pkg::CMD_LOAD_DESC: begin
                                if (i_item.ok) r_dld[w_waddr] <= 1'b1;
                            end
                            default: begin
                                r_fid   <= i_item.fid;
                                r_fsize <= i_item.fsize;
                                r_fdata <= i_item.data;
                                r_slot  <= '0;
                                r_acc   <= 1'b0;
                                r_state <= ST_SLOT;
                            end
                        endcase
                    end
                end
                ST_SLOT: begin
                    r_entry <= 4'd0;
                    r_off   <= 4'd0;
                    if (r_idl[r_slot] && !r_idw[r_slot][31] &&
                        r_idw[r_slot][10:0] == r_fid &&
                        32'(r_mcnt[r_slot]) <= MAX_ENTRIES) begin
                        r_state <= ST_ENTRY;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_ENTRY: begin
                    // RAM read address is live this cycle; data next
                    r_state <= (8'(r_entry) == r_mcnt[r_slot]) ? ST_END : ST_EXEC;
                end
                ST_EXEC: begin
                    if (!w_wok || w_need > 5'(r_fsize)) begin
                        r_state <= ST_NEXT;
                    end else if (w_free) begin
                        o_valid <= 1'b1;
                        o_kind  <= 1'b0;
                        o_last  <= 1'b0;
                        o_data  <= {4'd0, 1'b0, w_bytes, w_val,
                                    w_desc[15:8], w_desc[31:16]};
                        r_off   <= w_need[3:0];
                        r_entry <= r_entry + 4'd1;
                        r_state <= ST_ENTRY;
                    end
                end
                ST_END: begin
                    if (r_off == r_fsize) begin
                        r_acc   <= 1'b1;
                        r_state <= ST_VERDICT;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (r_slot == SW'(SLOTS - 1)) begin
                        r_state <= ST_VERDICT;
                    end else begin
                        r_slot  <= r_slot + SW'(1);
                        r_state <= ST_SLOT;
                    end
                end
                ST_VERDICT: begin
                    if (w_free) begin
                        o_valid <= 1'b1;
                        o_kind  <= 1'b1;
                        o_last  <= 1'b1;
                        o_data  <= {4'd0, r_acc, 59'd0};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/can_rpdo_demapper_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata                                   tuser      tlast
// s_axis   in   slot,entry,table_word,fid,size,data     command    -
// m_axis   out  index,subindex,value,byte_count,accept  kind       last
//
// Loads are handled by the engine in its idle state. A frame starts from
// idle; each slot is then checked in turn, and a matched slot walks its
// descriptors one RAM read at a time and checks that they use the whole
// frame size. The verdict follows the accepting slot or the last slot.
// A 2-entry queue lets input be taken while the engine works.
// Reset is synchronous active low; loaded bits and counts clear at once.
// Output stalls hold the engine; a full queue drops s_axis_tready.
module can_rpdo_demapper_top #(
    parameter int unsigned SLOTS       = 4,
    parameter int unsigned MAX_ENTRIES = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // slot[1:0] entry[4:2] table_word[36:5] frame_id[47:37]
    // frame_size[51:48] frame_data[115:52]
    input  wire logic [119:0] i_s_axis_tdata,
    input  wire logic [1:0]   i_s_axis_tuser,   // command
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // object_index[15:0] object_subindex[23:16] write_value[55:24]
    // byte_count[58:56] accepted[59]
    output logic [63:0]       o_m_axis_tdata,
    output logic              o_m_axis_tuser,   // kind
    output logic              o_m_axis_tlast
);
    logic            w_avail, w_pop;
    crpd_pkg::t_item w_item;

    crpd_front #(.SLOTS(SLOTS), .MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_cmd  (i_s_axis_tuser),
        .i_data (i_s_axis_tdata),
        .o_avail(w_avail),
        .o_item (w_item),
        .i_pop  (w_pop)
    );

    crpd_engine #(.SLOTS(SLOTS), .MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_avail(w_avail),
        .i_item (w_item),
        .o_pop  (w_pop),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_data (o_m_axis_tdata),
        .o_kind (o_m_axis_tuser),
        .o_last (o_m_axis_tlast)
    );
endmodule
`default_nettype wire

// ----- sv/crpd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module crpd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed under stall");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tlast == o_m_axis_tuser)
        else $error("tlast not on verdict only");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[58:0] == 59'd0)
        else $error("verdict carries write fields");

    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[58:56] != 3'd0 && o_m_axis_tdata[58:56] <= 3'd4 &&
            !o_m_axis_tdata[59])
        else $error("bad write byte count");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind can_rpdo_demapper_top crpd_checker u_crpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);
`default_nettype wire
